>>> hw/rtl/handshake_frame_receiver_assert.svh
// Assertion macros used by the frame receiver RTL.
`ifndef HANDSHAKE_FRAME_RECEIVER_ASSERT_SVH
`define HANDSHAKE_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hfr_pkg.sv
// Types and constants shared by the frame receiver modules.
`default_nettype none

package hfr_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_data;
    logic       consumer_busy;
  } hfr_in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        wr_valid;
    logic        wr_bank;
    logic [11:0] wr_addr;
    logic [7:0]  wr_data;
    logic        frame_done;
    logic        swapped;
    logic        transmit_bank;
    logic [31:0] fail_count;
    logic        busy_res;
    logic        last;
  } hfr_out_t;

  // Result queue: an abort pushes two transactions at once.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

endpackage

`default_nettype wire

>>> hw/rtl/hfr_res_fifo.sv
// Four-entry queue: one or two results in per cycle, one out unless stalled.
`default_nettype none

module hfr_res_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic             push_two,
  input  wire hfr_pkg::hfr_out_t wdata0,
  input  wire hfr_pkg::hfr_out_t wdata1,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output hfr_pkg::hfr_out_t     out_data,
  output logic [2:0]            count
);
  import hfr_pkg::*;

  hfr_out_t               mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RES_PTR_W-1:0]   wr_ptr_p1;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + RES_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push) + RES_PTR_W'(push_two);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(push) + RES_CNT_W'(push_two) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata0;
    end
    if (push_two) begin
      mem_r[wr_ptr_p1] <= wdata1;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/handshake_frame_receiver.sv
// Top level of the handshake frame receiver: request/receive sequencing and result queue.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------
//  in_     | input     | in_valid / in_stall  | hfr_in_t  (command, byte)
//  out_    | output    | out_valid / out_stall| hfr_out_t (tx, write, status)
//  cfg_    | input     | cfg_we               | cfg_addr, cfg_wdata
//
// A transaction is registered on entry and processed from that register once the
// result queue has room; its results are written into the queue and offered from there.
// One transaction is taken per cycle while the result queue has room.
// An abort yields two results; a four-entry result queue absorbs them and
// processing only waits when fewer than two queue slots are free.
// Reset is synchronous and returns the phase to idle and registers to defaults.
`default_nettype none
`include "handshake_frame_receiver_assert.svh"

module handshake_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire hfr_pkg::hfr_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output hfr_pkg::hfr_out_t   out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_addr,
  input  wire logic [21:0]    cfg_wdata
);
  import hfr_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_REQ  = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_SWAP  = 2'd3;

  localparam logic [1:0] CFG_FRAME_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_REQUEST_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_ABORT_TIMEOUT   = 2'd2;

  localparam logic [7:0]  CH_REQ    = 8'h72;
  localparam logic [7:0]  CH_START  = 8'h73;
  localparam logic [7:0]  CH_FAIL   = 8'h66;
  localparam logic [21:0] TIMER_MAX = 22'h3FFFFF;
  localparam int unsigned LEN_W     = 13;

  // Configuration registers.
  logic [LEN_W-1:0] frame_length_r;
  logic [21:0]      request_timeout_r;
  logic [21:0]      abort_timeout_r;

  // Input register.
  hfr_in_t          in_item_r;
  logic             in_vld_r, in_vld_nxt;
  logic             in_acc;
  logic             adv;

  // Sequencer state.
  logic [1:0]       phase_r, phase_nxt, phase_eff;
  logic [LEN_W-1:0] byte_count_r, byte_count_nxt, byte_inc, eff_len;
  logic [21:0]      wait_timer_r, wait_timer_nxt, timer_inc;
  logic [31:0]      failures_r, failures_nxt;
  logic             receive_bank_r, receive_bank_nxt;

  hfr_out_t         res0, res1;
  logic             abort;
  logic [2:0]       q_count;
  logic             q_room;

  assign q_room   = (q_count <= 3'(RES_DEPTH - 2));
  assign adv      = in_vld_r && q_room;
  assign in_stall = in_vld_r && !q_room;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    if (frame_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(frame_length_r) > MAX_FRAME_BYTES) begin
      eff_len = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      eff_len = frame_length_r;
    end
  end

  assign phase_eff = ((phase_r == PH_REQ) || (phase_r == PH_RECV)) ? phase_r : PH_IDLE;
  assign byte_inc  = byte_count_r + LEN_W'(1);
  assign timer_inc = (wait_timer_r != TIMER_MAX) ? (wait_timer_r + 22'd1) : wait_timer_r;

  always_comb begin
    phase_nxt        = phase_eff;
    byte_count_nxt   = byte_count_r;
    wait_timer_nxt   = wait_timer_r;
    failures_nxt     = failures_r;
    receive_bank_nxt = receive_bank_r;
    abort            = 1'b0;
    res0             = '0;

    case (in_item_r.command)
      CMD_START: begin
        if (phase_eff == PH_IDLE) begin
          res0.tx_valid  = 1'b1;
          res0.tx_byte   = CH_REQ;
          phase_nxt      = PH_REQ;
          wait_timer_nxt = '0;
        end
      end
      CMD_BYTE: begin
        if (phase_eff == PH_REQ) begin
          res0.tx_valid  = 1'b1;
          wait_timer_nxt = '0;
          if (in_item_r.rx_data == CH_REQ) begin
            res0.tx_byte   = CH_START;
            phase_nxt      = PH_RECV;
            byte_count_nxt = '0;
          end else begin
            res0.tx_byte = CH_REQ;
          end
        end else if (phase_eff == PH_RECV) begin
          res0.wr_valid  = 1'b1;
          res0.wr_bank   = receive_bank_r;
          res0.wr_addr   = byte_count_r[11:0];
          res0.wr_data   = in_item_r.rx_data;
          byte_count_nxt = byte_inc;
          if (byte_inc >= eff_len) begin
            res0.frame_done = 1'b1;
            phase_nxt       = PH_IDLE;
            byte_count_nxt  = '0;
            wait_timer_nxt  = '0;
          end
        end
      end
      CMD_TICK: begin
        if (phase_eff == PH_REQ) begin
          wait_timer_nxt = timer_inc;
          if (timer_inc > request_timeout_r) begin
            res0.tx_valid  = 1'b1;
            res0.tx_byte   = CH_REQ;
            wait_timer_nxt = '0;
          end
        end else if (phase_eff == PH_RECV) begin
          wait_timer_nxt = timer_inc;
          if (timer_inc > abort_timeout_r) begin
            abort          = 1'b1;
            res0.tx_valid  = 1'b1;
            res0.tx_byte   = CH_FAIL;
            failures_nxt   = failures_r + 32'd1;
            phase_nxt      = PH_REQ;
            byte_count_nxt = '0;
            wait_timer_nxt = '0;
          end
        end
      end
      CMD_SWAP: begin
        if (!in_item_r.consumer_busy) begin
          receive_bank_nxt = ~receive_bank_r;
          res0.swapped     = 1'b1;
        end
      end
      default: begin
        phase_nxt = phase_eff;
      end
    endcase

    // Status fields show the state after this transaction in every result.
    res0.transmit_bank = ~receive_bank_nxt;
    res0.fail_count    = failures_nxt;
    res0.busy_res      = (phase_nxt == PH_REQ) || (phase_nxt == PH_RECV);
    res0.last          = !abort;

    // The request that follows an abort.
    res1               = '0;
    res1.tx_valid      = 1'b1;
    res1.tx_byte       = CH_REQ;
    res1.transmit_bank = res0.transmit_bank;
    res1.fail_count    = res0.fail_count;
    res1.busy_res      = res0.busy_res;
    res1.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r    <= LEN_W'(4096);
      request_timeout_r <= 22'd2000000;
      abort_timeout_r   <= 22'd100000;
      in_vld_r          <= 1'b0;
      phase_r           <= PH_IDLE;
      byte_count_r      <= '0;
      wait_timer_r      <= '0;
      failures_r        <= '0;
      receive_bank_r    <= 1'b1;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (adv) begin
        phase_r        <= phase_nxt;
        byte_count_r   <= byte_count_nxt;
        wait_timer_r   <= wait_timer_nxt;
        failures_r     <= failures_nxt;
        receive_bank_r <= receive_bank_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FRAME_LENGTH:    frame_length_r    <= cfg_wdata[LEN_W-1:0];
          CFG_REQUEST_TIMEOUT: request_timeout_r <= cfg_wdata;
          CFG_ABORT_TIMEOUT:   abort_timeout_r   <= cfg_wdata;
          default: begin
            frame_length_r <= frame_length_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
  end

  hfr_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .push_two  (adv && abort),
    .wdata0    (res0),
    .wdata1    (res1),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

  `HFR_ASSERT_NOW(a_queue_room, adv, q_count <= 3'(RES_DEPTH - 2), "result queue overrun")
  `HFR_ASSERT_NOW(a_abort_first_fail, adv && abort, res0.tx_byte == CH_FAIL, "abort without fail")
  `HFR_ASSERT_NEXT(a_done_to_idle, adv && res0.frame_done, phase_r == PH_IDLE, "frame end not idle")
  `HFR_ASSERT_NOW(a_idle_timer_clear, phase_r == PH_IDLE, wait_timer_r == '0, "timer live in idle")

endmodule

`default_nettype wire

>>> verif/handshake_frame_receiver_test.sv
// Self-checking testbench for the handshake frame receiver: directed and random transactions.
`timescale 1ns / 1ps

module handshake_frame_receiver_test;
  import hfr_pkg::*;

  localparam int unsigned FRAME_MAX = 4096;
  localparam int unsigned WATCHDOG_CYCLES = 2000;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_SWAP  = 2'd3;

  localparam logic [1:0] REG_FRAME_LEN     = 2'd0;
  localparam logic [1:0] REG_REQ_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_ABORT_TIMEOUT = 2'd2;

  localparam logic [7:0] CH_REQUEST = 8'h72;
  localparam logic [7:0] CH_START   = 8'h73;
  localparam logic [7:0] CH_FAIL    = 8'h66;

  localparam logic [21:0] TICKS_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_REQUEST = 2'd1,
    PH_RECEIVE = 2'd2
  } rx_phase_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  hfr_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  hfr_out_t    out_data;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [21:0] cfg_wdata;

  // Predicted state of the receiver and its registers.
  rx_phase_e   rx_phase = PH_IDLE;
  logic [12:0] byte_pos = '0;
  logic [21:0] wait_ticks = '0;
  logic [31:0] abort_total = '0;
  logic        rx_bank = 1'b1;
  logic [12:0] frame_len_reg = 13'd4096;
  logic [21:0] req_timeout_reg = 22'd2000000;
  logic [21:0] abort_timeout_reg = 22'd100000;

  hfr_out_t    pending_results[$];
  int unsigned active_items = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  handshake_frame_receiver #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned frame_limit();
    if (frame_len_reg == 0) return 1;
    if (frame_len_reg > FRAME_MAX) return FRAME_MAX;
    return 32'(frame_len_reg);
  endfunction

  // Updates the predicted state for one accepted transaction and queues its results.
  function automatic void advance_receiver(input hfr_in_t item);
    hfr_out_t res;
    hfr_out_t retry;
    logic     abort;
    res = '0;
    abort = 1'b0;
    if (item.command == CMD_TICK && rx_phase != PH_IDLE) active_items++;
    case (item.command)
      CMD_START: begin
        if (rx_phase == PH_IDLE) begin
          res.tx_valid = 1'b1;
          res.tx_byte = CH_REQUEST;
          rx_phase = PH_REQUEST;
          wait_ticks = '0;
        end
      end
      CMD_BYTE: begin
        if (rx_phase == PH_REQUEST) begin
          res.tx_valid = 1'b1;
          if (item.rx_data == CH_REQUEST) begin
            res.tx_byte = CH_START;
            rx_phase = PH_RECEIVE;
            byte_pos = '0;
          end else begin
            res.tx_byte = CH_REQUEST;
          end
          wait_ticks = '0;
        end else if (rx_phase == PH_RECEIVE) begin
          res.wr_valid = 1'b1;
          res.wr_bank = rx_bank;
          res.wr_addr = byte_pos[11:0];
          res.wr_data = item.rx_data;
          byte_pos = byte_pos + 13'd1;
          if (byte_pos >= frame_limit()) begin
            res.frame_done = 1'b1;
            rx_phase = PH_IDLE;
            byte_pos = '0;
            wait_ticks = '0;
          end
        end
      end
      CMD_TICK: begin
        if (rx_phase != PH_IDLE) begin
          if (wait_ticks != TICKS_MAX) wait_ticks = wait_ticks + 22'd1;
          if (rx_phase == PH_REQUEST) begin
            if (wait_ticks > req_timeout_reg) begin
              res.tx_valid = 1'b1;
              res.tx_byte = CH_REQUEST;
              wait_ticks = '0;
            end
          end else if (wait_ticks > abort_timeout_reg) begin
            abort = 1'b1;
            res.tx_valid = 1'b1;
            res.tx_byte = CH_FAIL;
            abort_total = abort_total + 32'd1;
            rx_phase = PH_REQUEST;
            byte_pos = '0;
            wait_ticks = '0;
          end
        end
      end
      default: begin
        if (!item.consumer_busy) begin
          rx_bank = ~rx_bank;
          res.swapped = 1'b1;
        end
      end
    endcase
    if (item.command != CMD_TICK && (res.tx_valid || res.wr_valid || res.swapped))
      active_items++;
    res.transmit_bank = ~rx_bank;
    res.fail_count = abort_total;
    res.busy_res = (rx_phase != PH_IDLE);
    if (abort) begin
      retry = '0;
      retry.tx_valid = 1'b1;
      retry.tx_byte = CH_REQUEST;
      retry.transmit_bank = res.transmit_bank;
      retry.fail_count = res.fail_count;
      retry.busy_res = res.busy_res;
      retry.last = 1'b1;
      pending_results.push_back(res);
      pending_results.push_back(retry);
    end else begin
      res.last = 1'b1;
      pending_results.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    err_count++;
  endtask

  task automatic check_field(input string label, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", label, got, want));
  endtask

  always @(posedge clk) begin : check_results
    hfr_out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = pending_results.pop_front();
          check_field("tx_valid", 32'(out_data.tx_valid), 32'(want.tx_valid));
          check_field("tx_byte", 32'(out_data.tx_byte), 32'(want.tx_byte));
          check_field("wr_valid", 32'(out_data.wr_valid), 32'(want.wr_valid));
          check_field("wr_bank", 32'(out_data.wr_bank), 32'(want.wr_bank));
          check_field("wr_addr", 32'(out_data.wr_addr), 32'(want.wr_addr));
          check_field("wr_data", 32'(out_data.wr_data), 32'(want.wr_data));
          check_field("frame_done", 32'(out_data.frame_done), 32'(want.frame_done));
          check_field("swapped", 32'(out_data.swapped), 32'(want.swapped));
          check_field("transmit_bank", 32'(out_data.transmit_bank),
                      32'(want.transmit_bank));
          check_field("fail_count", out_data.fail_count, want.fail_count);
          check_field("busy_res", 32'(out_data.busy_res), 32'(want.busy_res));
          check_field("last", 32'(out_data.last), 32'(want.last));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) advance_receiver(in_data);
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no transaction for %0d cycles", idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_event(input logic [1:0] cmd, input logic [7:0] data,
                            input logic busy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.command = cmd;
    in_data.rx_data = data;
    in_data.consumer_busy = busy;
    forever begin
      @(posedge clk);
      if (in_stall === 1'b0) break;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [21:0] value);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    case (idx)
      REG_FRAME_LEN: frame_len_reg = value[12:0];
      REG_REQ_TIMEOUT: req_timeout_reg = value;
      REG_ABORT_TIMEOUT: abort_timeout_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Brings the receiver back to idle by completing the current frame.
  task automatic finish_frame();
    if (rx_phase == PH_REQUEST) send_event(CMD_BYTE, CH_REQUEST, 1'($urandom_range(1)));
    while (rx_phase == PH_RECEIVE)
      send_event(CMD_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic test_reset_defaults();
    send_event(CMD_TICK, 8'h00, 1'b0);
    send_event(CMD_BYTE, CH_REQUEST, 1'b1);
    send_event(CMD_SWAP, 8'hFF, 1'b1);
    send_event(CMD_SWAP, 8'h00, 1'b0);
    send_event(CMD_START, 8'h00, 1'b0);
    send_event(CMD_START, 8'hFF, 1'b1);
    send_event(CMD_BYTE, 8'hFF, 1'b0);
    send_event(CMD_TICK, 8'h00, 1'b0);
    send_event(CMD_BYTE, CH_REQUEST, 1'b0);
    send_event(CMD_BYTE, 8'h00, 1'b0);
    send_event(CMD_BYTE, 8'hFF, 1'b1);
    send_event(CMD_START, 8'h00, 1'b0);
    send_event(CMD_TICK, 8'hFF, 1'b1);
    send_event(CMD_SWAP, 8'h00, 1'b1);
    // The banks toggle in the middle of the frame; later bytes go to the new bank.
    send_event(CMD_SWAP, 8'h00, 1'b0);
    send_event(CMD_BYTE, 8'h55, 1'b0);
    send_event(CMD_BYTE, 8'hAA, 1'b0);
    // Shorten the open frame so that two more bytes complete it.
    drain_results();
    write_reg(REG_FRAME_LEN, 22'd6);
    finish_frame();
    drain_results();
  endtask

  task automatic test_length_clamp();
    // Only 13 bits are kept; 8191 is above the largest frame and gets clamped,
    // so a short run of bytes leaves the frame open.
    write_reg(REG_FRAME_LEN, 22'h3FFFFF);
    send_event(CMD_START, 8'h00, 1'b0);
    send_event(CMD_BYTE, CH_REQUEST, 1'b0);
    repeat (8) send_event(CMD_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
    drain_results();
    // Bit 13 is dropped, so the open frame now ends at ten bytes.
    write_reg(REG_FRAME_LEN, 22'h200A);
    finish_frame();
    drain_results();
  endtask

  task automatic test_zero_timeouts();
    write_reg(REG_FRAME_LEN, 22'd0);
    write_reg(REG_REQ_TIMEOUT, 22'd0);
    write_reg(REG_ABORT_TIMEOUT, 22'd0);
    send_event(CMD_START, 8'h00, 1'b0);
    send_event(CMD_TICK, 8'h00, 1'b0);
    send_event(CMD_TICK, 8'h00, 1'b0);
    send_event(CMD_BYTE, CH_REQUEST, 1'b0);
    send_event(CMD_TICK, 8'h00, 1'b0);
    send_event(CMD_BYTE, 8'h71, 1'b0);
    send_event(CMD_BYTE, CH_REQUEST, 1'b1);
    send_event(CMD_BYTE, 8'hA5, 1'b0);
    send_event(CMD_START, 8'h00, 1'b0);
    send_event(CMD_BYTE, CH_REQUEST, 1'b0);
    send_event(CMD_SWAP, 8'h00, 1'b0);
    send_event(CMD_BYTE, 8'h5A, 1'b0);
    drain_results();
  endtask

  task automatic test_max_timeouts();
    write_reg(REG_FRAME_LEN, 22'd2);
    write_reg(REG_REQ_TIMEOUT, 22'h3FFFFF);
    write_reg(REG_ABORT_TIMEOUT, 22'h3FFFFF);
    send_event(CMD_START, 8'h00, 1'b0);
    repeat (5) send_event(CMD_TICK, 8'h00, 1'b0);
    send_event(CMD_BYTE, CH_REQUEST, 1'b0);
    repeat (3) send_event(CMD_TICK, 8'hFF, 1'b1);
    send_event(CMD_BYTE, 8'h0F, 1'b0);
    send_event(CMD_BYTE, 8'hF0, 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_set[4] = '{0, 68, 0, 17};
    int unsigned stall_set[4] = '{0, 0, 68, 17};
    int unsigned stop_at;
    int unsigned pick;
    logic        stall_frame;
    for (int p = 0; p < 4; p++) begin
      finish_frame();
      drain_results();
      write_reg(REG_FRAME_LEN, (p == 0) ? 22'd1 : 22'($urandom_range(24, 1)));
      write_reg(REG_REQ_TIMEOUT, 22'($urandom_range(10, 1)));
      write_reg(REG_ABORT_TIMEOUT, 22'($urandom_range(30, 3)));
      send_idle_pct = idle_set[p];
      recv_stall_pct = stall_set[p];
      stop_at = active_items + 275;
      while (active_items < stop_at) begin
        if ($urandom_range(99) < 72) begin
          // A well-formed request and frame with random content and interruptions.
          send_event(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
          repeat ($urandom_range(2)) begin
            if ($urandom_range(1)) begin
              send_event(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
              send_event(CMD_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
          end
          if ($urandom_range(99) < 20)
            repeat (req_timeout_reg + 1) send_event(CMD_TICK, 8'($urandom_range(255)), 1'b0);
          send_event(CMD_BYTE, CH_REQUEST, 1'($urandom_range(1)));
          stall_frame = ($urandom_range(99) < 15);
          while (rx_phase == PH_RECEIVE) begin
            pick = $urandom_range(99);
            if (stall_frame || pick < 10)
              send_event(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (pick < 15)
              send_event(CMD_SWAP, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
              send_event(CMD_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
          end
        end else begin
          send_event(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_length_clamp();
    test_zero_timeouts();
    test_max_timeouts();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
